// File: hw/rtl/udpfp_pkg.sv
// ----------------------------------------------------------------------------
// udpfp_pkg
// Types and constants shared by the UDP frame payload parser.
// ----------------------------------------------------------------------------
package udpfp_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 65536;
	localparam int SUM_W               = 18;

	localparam logic [31:0] LINK_TYPE_RST   = 32'd1;
	localparam logic [31:0] SNAP_LEN_RST    = 32'd65535;
	localparam logic [31:0] LINK_ETHERNET   = 32'd1;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP    = 8'h11;
	localparam logic [3:0]  IP_VERSION_4    = 4'd4;
	localparam logic [3:0]  IP_MIN_IHL      = 4'd5;
	localparam int          ETH_HDR         = 14;
	localparam int          UDP_HDR         = 8;
	localparam int          OFF_ETYPE_HI    = 12;
	localparam int          OFF_ETYPE_LO    = 13;
	localparam int          OFF_IP_VER      = 14;
	localparam int          OFF_IP_LEN_HI   = 16;
	localparam int          OFF_IP_LEN_LO   = 17;
	localparam int          OFF_IP_PROTO    = 23;
	localparam int          OFF_L4_MIN      = 34;

	typedef enum logic {
		OP_HEADER = 1'b0,
		OP_BYTE   = 1'b1
	} op_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef enum logic {
		REG_LINK_TYPE = 1'b0,
		REG_SNAP_LEN  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_UDP       = 4'd0,
		ST_EMPTY     = 4'd1,
		ST_TRUNC     = 4'd2,
		ST_FATAL     = 4'd3,
		ST_HALTED    = 4'd4,
		ST_NOT_ETH   = 4'd5,
		ST_SHORT_ETH = 4'd6,
		ST_NOT_IPV4  = 4'd7,
		ST_BAD_IHL   = 4'd8,
		ST_IP_BOUNDS = 4'd9,
		ST_NOT_UDP   = 4'd10,
		ST_UDP_BOUND = 4'd11,
		ST_STRAY     = 4'd12
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic        last_payload;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [15:0] udp_length;
		status_t     status_code;
	} result_t;

endpackage

// File: hw/rtl/udp_frame_payload_parser.sv
// An accepted word is registered in the input stage, parsed combinationally and
// its results are written into the output queue that feeds the master side.
// Throughput: one input word per cycle while the output queue has room for
// two results; the single output port drains the 4-entry queue.
// Reset: arst_n clears all control state and loads link_type 1 and
// snapshot_length 65535; the block is ready right after reset.
// ----------------------------------------------------------------------------
// udp_frame_payload_parser
// Parses Ethernet/IPv4/UDP headers from capture records and emits the UDP
// payload bytes followed by one status word per frame.
// ----------------------------------------------------------------------------
module udp_frame_payload_parser #(
	parameter int MAX_FRAME_BYTES = udpfp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // captured_length, original_length, data_byte
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // payload_byte, source_port, destination_port,
	                               // udp_length, status_code, zero fill
	output logic        m_tlast,   // last_payload
	output logic        m_tuser    // kind
);

	localparam int OW      = $clog2(MAX_FRAME_BYTES + 1);
	localparam int SW      = udpfp_pkg::SUM_W;
	localparam int DEPTH   = 4;
	localparam int PW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);

	// configuration
	logic [31:0] link_type_q;
	logic [31:0] snap_len_q;

	// input stage
	logic        v_s1;
	logic        op_s1;
	logic [31:0] cap_s1;
	logic [31:0] orig_s1;
	logic [7:0]  byte_s1;

	// parser state
	logic             halted_q;
	logic             open_q;
	logic [OW-1:0]    off_q;
	logic [OW-1:0]    len_q;
	logic [7:0]       etype_hi_q;
	logic [3:0]       ihw_q;
	logic [15:0]      ip_tl_q;
	logic [15:0]      sport_q;
	logic [15:0]      dport_q;
	logic [15:0]      ulen_q;
	udpfp_pkg::status_t verdict_q;

	// next state
	logic             halted_d;
	logic             open_d;
	logic [OW-1:0]    off_d;
	logic [OW-1:0]    len_d;
	logic [7:0]       etype_hi_d;
	logic [3:0]       ihw_d;
	logic [15:0]      ip_tl_d;
	logic [15:0]      sport_d;
	logic [15:0]      dport_d;
	logic [15:0]      ulen_d;
	udpfp_pkg::status_t verdict_d;

	udpfp_pkg::result_t res0;
	udpfp_pkg::result_t res1;
	logic [1:0]         n_push;

	// output queue
	udpfp_pkg::result_t fifo_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic               go;
	logic               pop;
	udpfp_pkg::result_t head;

	function automatic udpfp_pkg::result_t mk_status(
		input udpfp_pkg::status_t st,
		input logic [15:0]        sp,
		input logic [15:0]        dp,
		input logic [15:0]        ul
	);
		udpfp_pkg::result_t r;
		r.kind         = udpfp_pkg::KIND_STATUS;
		r.payload_byte = '0;
		r.last_payload = 1'b0;
		r.status_code  = st;
		if (st == udpfp_pkg::ST_UDP) begin
			r.source_port      = sp;
			r.destination_port = dp;
			r.udp_length       = ul;
		end else begin
			r.source_port      = '0;
			r.destination_port = '0;
			r.udp_length       = '0;
		end
		return r;
	endfunction

	assign go       = v_s1 && (cnt_q <= CW'(DEPTH - 2));
	assign s_tready = !v_s1 || go;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= udpfp_pkg::LINK_TYPE_RST;
			snap_len_q  <= udpfp_pkg::SNAP_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				udpfp_pkg::REG_LINK_TYPE: link_type_q <= cfg_wdata;
				udpfp_pkg::REG_SNAP_LEN:  snap_len_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			cap_s1  <= s_tdata[31:0];
			orig_s1 <= s_tdata[63:32];
			byte_s1 <= s_tdata[71:64];
		end
	end

	always_comb begin
		logic [SW-1:0] o;
		logic [SW-1:0] len;
		logic [SW-1:0] h;
		logic [SW-1:0] hn;
		logic [SW-1:0] u;
		logic [SW-1:0] tl;
		logic [SW-1:0] ul;
		logic [15:0]   tl_new;
		logic [15:0]   ul_new;
		logic          fatal;

		halted_d   = halted_q;
		open_d     = open_q;
		off_d      = off_q;
		len_d      = len_q;
		etype_hi_d = etype_hi_q;
		ihw_d      = ihw_q;
		ip_tl_d    = ip_tl_q;
		sport_d    = sport_q;
		dport_d    = dport_q;
		ulen_d     = ulen_q;
		verdict_d  = verdict_q;
		res0       = mk_status(udpfp_pkg::ST_HALTED, '0, '0, '0);
		res1       = res0;
		n_push     = 2'd0;

		o      = SW'(off_q);
		len    = SW'(len_q);
		h      = SW'({ihw_q, 2'b00});
		hn     = SW'({byte_s1[3:0], 2'b00});
		u      = SW'(udpfp_pkg::ETH_HDR) + h;
		tl     = SW'(ip_tl_q);
		ul     = SW'(ulen_q);
		tl_new = {ip_tl_q[15:8], byte_s1};
		ul_new = {ulen_q[15:8], byte_s1};
		fatal  = (orig_s1 < cap_s1) || (cap_s1 > snap_len_q) ||
		         ({1'b0, cap_s1} > 33'(MAX_FRAME_BYTES));

		if (halted_q) begin
			n_push = 2'd1;
		end else if (op_s1 == udpfp_pkg::OP_HEADER) begin
			if (open_q) begin
				res0   = mk_status(udpfp_pkg::ST_TRUNC, sport_q, dport_q, ulen_q);
				n_push = 2'd1;
			end
			open_d    = 1'b0;
			sport_d   = '0;
			dport_d   = '0;
			ulen_d    = '0;
			etype_hi_d = '0;
			ihw_d     = '0;
			ip_tl_d   = '0;
			off_d     = '0;
			len_d     = '0;
			verdict_d = udpfp_pkg::ST_UDP;
			if (fatal) begin
				halted_d = 1'b1;
				res1     = mk_status(udpfp_pkg::ST_FATAL, '0, '0, '0);
				n_push   = n_push + 2'd1;
			end else if (cap_s1 == '0) begin
				res1   = mk_status((orig_s1 != '0) ? udpfp_pkg::ST_TRUNC : udpfp_pkg::ST_EMPTY,
				                   '0, '0, '0);
				n_push = n_push + 2'd1;
			end else begin
				len_d  = cap_s1[OW-1:0];
				open_d = 1'b1;
				if (cap_s1 < orig_s1) begin
					verdict_d = udpfp_pkg::ST_TRUNC;
				end else if (link_type_q != udpfp_pkg::LINK_ETHERNET) begin
					verdict_d = udpfp_pkg::ST_NOT_ETH;
				end else if (cap_s1 < 32'(udpfp_pkg::ETH_HDR)) begin
					verdict_d = udpfp_pkg::ST_SHORT_ETH;
				end
			end
			// only one result: move it to the first slot
			if (!open_q) begin
				res0 = res1;
			end
		end else if (!open_q) begin
			res0   = mk_status(udpfp_pkg::ST_STRAY, '0, '0, '0);
			n_push = 2'd1;
		end else begin
			if (verdict_q == udpfp_pkg::ST_UDP) begin
				if (o == SW'(udpfp_pkg::OFF_ETYPE_HI)) begin
					etype_hi_d = byte_s1;
				end else if (o == SW'(udpfp_pkg::OFF_ETYPE_LO)) begin
					if ({etype_hi_q, byte_s1} != udpfp_pkg::ETHERTYPE_IPV4) begin
						verdict_d = udpfp_pkg::ST_NOT_IPV4;
					end else if (len <= SW'(udpfp_pkg::ETH_HDR)) begin
						verdict_d = udpfp_pkg::ST_IP_BOUNDS;
					end
				end else if (o == SW'(udpfp_pkg::OFF_IP_VER)) begin
					ihw_d = byte_s1[3:0];
					if (byte_s1[7:4] != udpfp_pkg::IP_VERSION_4 ||
					    byte_s1[3:0] < udpfp_pkg::IP_MIN_IHL) begin
						verdict_d = udpfp_pkg::ST_BAD_IHL;
					end else if (SW'(udpfp_pkg::ETH_HDR) + hn > len) begin
						verdict_d = udpfp_pkg::ST_IP_BOUNDS;
					end
				end else if (o == SW'(udpfp_pkg::OFF_IP_LEN_HI)) begin
					ip_tl_d = {byte_s1, 8'h00};
				end else if (o == SW'(udpfp_pkg::OFF_IP_LEN_LO)) begin
					ip_tl_d = tl_new;
					if (SW'(tl_new) + SW'(udpfp_pkg::ETH_HDR) > len) begin
						verdict_d = udpfp_pkg::ST_IP_BOUNDS;
					end else if (h > SW'(tl_new)) begin
						verdict_d = udpfp_pkg::ST_IP_BOUNDS;
					end
				end else if (o == SW'(udpfp_pkg::OFF_IP_PROTO)) begin
					if (byte_s1 != udpfp_pkg::IP_PROTO_UDP) begin
						verdict_d = udpfp_pkg::ST_NOT_UDP;
					end else if (h + SW'(udpfp_pkg::UDP_HDR) > tl) begin
						verdict_d = udpfp_pkg::ST_UDP_BOUND;
					end
				end else if (o >= SW'(udpfp_pkg::OFF_L4_MIN)) begin
					if (o == u) begin
						sport_d = {byte_s1, 8'h00};
					end else if (o == u + SW'(1)) begin
						sport_d = {sport_q[15:8], byte_s1};
					end else if (o == u + SW'(2)) begin
						dport_d = {byte_s1, 8'h00};
					end else if (o == u + SW'(3)) begin
						dport_d = {dport_q[15:8], byte_s1};
					end else if (o == u + SW'(4)) begin
						ulen_d = {byte_s1, 8'h00};
					end else if (o == u + SW'(5)) begin
						ulen_d = ul_new;
						if (ul_new < 16'(udpfp_pkg::UDP_HDR) || h + SW'(ul_new) > tl) begin
							verdict_d = udpfp_pkg::ST_UDP_BOUND;
						end
					end else if (o >= u + SW'(udpfp_pkg::UDP_HDR) && o < u + ul) begin
						res0.kind             = udpfp_pkg::KIND_PAYLOAD;
						res0.payload_byte     = byte_s1;
						res0.last_payload     = (o == u + ul - SW'(1));
						res0.source_port      = sport_q;
						res0.destination_port = dport_q;
						res0.udp_length       = ulen_q;
						res0.status_code      = udpfp_pkg::ST_UDP;
						n_push                = 2'd1;
					end
				end
			end
			if (o + SW'(1) >= len) begin
				open_d = 1'b0;
				if (n_push == 2'd1) begin
					res1 = mk_status(verdict_d, sport_d, dport_d, ulen_d);
				end else begin
					res0 = mk_status(verdict_d, sport_d, dport_d, ulen_d);
				end
				n_push = n_push + 2'd1;
			end else begin
				off_d = off_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q   <= 1'b0;
			open_q     <= 1'b0;
			off_q      <= '0;
			len_q      <= '0;
			etype_hi_q <= '0;
			ihw_q      <= '0;
			ip_tl_q    <= '0;
			sport_q    <= '0;
			dport_q    <= '0;
			ulen_q     <= '0;
			verdict_q  <= udpfp_pkg::ST_UDP;
		end else if (go) begin
			halted_q   <= halted_d;
			open_q     <= open_d;
			off_q      <= off_d;
			len_q      <= len_d;
			etype_hi_q <= etype_hi_d;
			ihw_q      <= ihw_d;
			ip_tl_q    <= ip_tl_d;
			sport_q    <= sport_d;
			dport_q    <= dport_d;
			ulen_q     <= ulen_d;
			verdict_q  <= verdict_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (go && n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (go) begin
				wr_ptr_q <= wr_ptr_q + PW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (go ? CW'(n_push) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last_payload;
	assign m_tdata  = {4'h0, head.status_code, head.udp_length, head.destination_port,
	                   head.source_port, head.payload_byte};

`ifndef NO_ASSERTIONS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("output queue overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1)
		else $error("input stalled with empty stage");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == udpfp_pkg::KIND_PAYLOAD) |->
			(head.status_code == udpfp_pkg::ST_UDP))
		else $error("payload word carries a status");
`endif

endmodule
